// ===== sv/fractional_pll_word_message_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the PLL word message unit
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_PLL_WORD_MESSAGE_UNIT_MACROS_SVH
`define FRACTIONAL_PLL_WORD_MESSAGE_UNIT_MACROS_SVH

// same-cycle implication
`define FPWM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpwm assertion failed");

// next-cycle implication
`define FPWM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpwm assertion failed");

`endif

// ===== sv/fpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpwm_pkg
// Widths, constants and register codes of the PLL word message unit.
// ----------------------------------------------------------------------------
package fpwm_pkg;

   localparam int VCO_W              = 33;
   localparam int REF_W              = 32;
   localparam int REM_W              = REF_W;
   localparam int BYTE_W             = 8;
   localparam int MSG_BYTES          = 7;
   localparam int MSG_W              = MSG_BYTES * BYTE_W;
   localparam int INT_W              = 16;
   localparam int FRAC_FIELD_W       = 24;
   localparam int IDX_W              = 3;
   localparam int FRACT_BITS_DEFAULT = 20;

   localparam logic [VCO_W-1:0]  OFFSET_HZ        = 33'd3000000;
   localparam logic [VCO_W-1:0]  DIV_THRESHOLD_HZ = 33'd2750000000;
   localparam logic [REF_W-1:0]  REF_RESET        = 32'd100000000;
   localparam logic [INT_W-1:0]  INT_BIAS         = 16'd4;
   localparam logic [BYTE_W-1:0] ID_RECEIVE       = 8'd1;
   localparam logic [BYTE_W-1:0] ID_TRANSMIT      = 8'd2;
   localparam logic [IDX_W-1:0]  LAST_IDX         = IDX_W'(MSG_BYTES - 1);

   // configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_LSB = 2;
   localparam logic REG_REF_FREQ = 1'b0;

endpackage

// ===== sv/fpwm_req_if.sv =====
// ----------------------------------------------------------------------------
// fpwm_req_if
// Request channel: VCO frequency and receive/transmit select.
// ----------------------------------------------------------------------------
interface fpwm_req_if;
   import fpwm_pkg::*;

   logic             valid;
   logic             ready;
   logic [VCO_W-1:0] vco_hz;
   logic             is_transmit;

   modport source (output valid, output vco_hz, output is_transmit, input ready);
   modport sink   (input valid, input vco_hz, input is_transmit, output ready);

endinterface

// ===== sv/fpwm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fpwm_rsp_if
// Result channel: one message byte per transfer with an end marker.
// ----------------------------------------------------------------------------
interface fpwm_rsp_if;
   import fpwm_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);

endinterface

// ===== sv/fpwm_front.sv =====
// ----------------------------------------------------------------------------
// fpwm_front
// Input stage: picks the output divider and scales the VCO frequency into
// the dividend that enters the divider chain.
// ----------------------------------------------------------------------------
module fpwm_front #(
   parameter int FRACT_BITS = fpwm_pkg::FRACT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             up_valid,
   input  logic [fpwm_pkg::VCO_W-1:0]       up_vco_hz,
   input  logic                             up_is_transmit,
   output logic                             dn_valid,
   output logic [fpwm_pkg::VCO_W+FRACT_BITS-1:0] dn_num,
   output logic                             dn_div,
   output logic                             dn_tx
);
   import fpwm_pkg::*;

   localparam int NUM_W = VCO_W + FRACT_BITS;

   logic             valid_ff;
   logic [NUM_W-1:0] num_ff, num_in;
   logic             div_ff, div_in;
   logic             tx_ff;
   logic [VCO_W-1:0] d_hz;
   logic [VCO_W-1:0] x_hz;

   always_comb begin
      div_in = up_vco_hz > DIV_THRESHOLD_HZ;
      d_hz   = (up_vco_hz < OFFSET_HZ) ? '0 : up_vco_hz - OFFSET_HZ;
      // without the divider d stays below 2^32, so doubling fits
      x_hz   = div_in ? d_hz : {d_hz[VCO_W-2:0], 1'b0};
      num_in = {x_hz, {FRACT_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
         div_ff <= div_in;
         tx_ff  <= up_is_transmit;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_num   = num_ff;
   assign dn_div   = div_ff;
   assign dn_tx    = tx_ff;

endmodule

// ===== sv/fpwm_cell.sv =====
// ----------------------------------------------------------------------------
// fpwm_cell
// One restoring-division step: shift in a dividend bit, compare against the
// reference, subtract, and hand the partial result to the next cell.
// ----------------------------------------------------------------------------
module fpwm_cell #(
   parameter int NUM_W = fpwm_pkg::VCO_W + fpwm_pkg::FRACT_BITS_DEFAULT,
   parameter int QUO_W = fpwm_pkg::INT_W + fpwm_pkg::FRACT_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [fpwm_pkg::REF_W-1:0]  ref_freq,
   input  logic                        up_valid,
   input  logic [fpwm_pkg::REM_W-1:0]  up_rem,
   input  logic [NUM_W-1:0]            up_num,
   input  logic [QUO_W-1:0]            up_quo,
   input  logic                        up_div,
   input  logic                        up_tx,
   output logic                        dn_valid,
   output logic [fpwm_pkg::REM_W-1:0]  dn_rem,
   output logic [NUM_W-1:0]            dn_num,
   output logic [QUO_W-1:0]            dn_quo,
   output logic                        dn_div,
   output logic                        dn_tx
);
   import fpwm_pkg::*;

   logic             valid_ff;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff;
   logic [QUO_W-1:0] quo_ff;
   logic             div_ff;
   logic             tx_ff;
   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             take;

   always_comb begin
      trial  = {up_rem, up_num[NUM_W-1]};
      diff   = trial - {1'b0, ref_freq};
      take   = trial >= {1'b0, ref_freq};
      // a zero reference takes every step, giving an all-ones quotient
      rem_in = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         num_ff <= {up_num[NUM_W-2:0], 1'b0};
         quo_ff <= {up_quo[QUO_W-2:0], take};
         div_ff <= up_div;
         tx_ff  <= up_tx;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_num   = num_ff;
   assign dn_quo   = quo_ff;
   assign dn_div   = div_ff;
   assign dn_tx    = tx_ff;

endmodule

// ===== sv/fpwm_serializer.sv =====
// ----------------------------------------------------------------------------
// fpwm_serializer
// Formats the quotient into the seven-byte command message and sends it
// one byte per transfer, first byte from the top of the shift register.
// ----------------------------------------------------------------------------
module fpwm_serializer #(
   parameter int FRACT_BITS = fpwm_pkg::FRACT_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       tail_valid,
   input  logic [fpwm_pkg::INT_W+FRACT_BITS-1:0]      tail_quo,
   input  logic                                       tail_div,
   input  logic                                       tail_tx,
   output logic                                       can_load,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [fpwm_pkg::BYTE_W-1:0]                rsp_out_byte,
   output logic                                       rsp_last
);
   import fpwm_pkg::*;

   logic                    busy_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [MSG_W-1:0]        msg_ff, msg_in;
   logic [INT_W-1:0]        int_field;
   logic [FRAC_FIELD_W-1:0] frac_field;
   logic [BYTE_W-1:0]       id_field;
   logic                    is_last;
   logic                    load;

   always_comb begin
      int_field  = tail_quo[INT_W+FRACT_BITS-1:FRACT_BITS] - INT_BIAS;
      frac_field = FRAC_FIELD_W'(tail_quo[FRACT_BITS-1:0]);
      id_field   = tail_tx ? ID_TRANSMIT : ID_RECEIVE;
      msg_in     = {id_field, int_field, frac_field, {(BYTE_W-1){1'b0}}, tail_div};
   end

   assign is_last  = idx_ff == LAST_IDX;
   // take the next message as the final byte of this one leaves
   assign can_load = !busy_ff || (rsp_ready && is_last);
   assign load     = tail_valid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (is_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         msg_ff <= msg_in;
      end else if (busy_ff && rsp_ready) begin
         msg_ff <= {msg_ff[MSG_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      end
   end

   assign rsp_valid    = busy_ff;
   assign rsp_out_byte = msg_ff[MSG_W-1:MSG_W-BYTE_W];
   assign rsp_last     = is_last;

endmodule

// ===== sv/fractional_pll_word_message_unit.sv =====
// ----------------------------------------------------------------------------
// fractional_pll_word_message_unit
// Path: a request passes the input stage, one division cell per dividend
//   bit and the output register before its first message byte leaves.
// Throughput: a new message loads as the final byte of the last one leaves;
//   one message byte per cycle while the response channel is ready.
// Reset: synchronous; clears all valid flags, reference returns to 100 MHz.
// ----------------------------------------------------------------------------
`include "fractional_pll_word_message_unit_macros.svh"

module fractional_pll_word_message_unit #(
   parameter int FRACT_BITS = fpwm_pkg::FRACT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fpwm_req_if.sink                             req_chan,
   fpwm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fpwm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [fpwm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [fpwm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import fpwm_pkg::*;

   localparam int NUM_W = VCO_W + FRACT_BITS;
   localparam int QUO_W = INT_W + FRACT_BITS;
   localparam int CELLS = NUM_W;

   logic [REF_W-1:0] ref_ff;
   logic             advance;
   logic             can_load;

   logic             chain_valid [0:CELLS];
   logic [REM_W-1:0] chain_rem   [0:CELLS];
   logic [NUM_W-1:0] chain_num   [0:CELLS];
   logic [QUO_W-1:0] chain_quo   [0:CELLS];
   logic             chain_div   [0:CELLS];
   logic             chain_tx    [0:CELLS];

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[REG_IDX_LSB] == REG_REF_FREQ) ? ref_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= REF_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[REG_IDX_LSB] == REG_REF_FREQ)) begin
         ref_ff <= csr_pwdata;
      end
   end

   // hold the whole chain while the tail waits on the serializer
   assign advance        = !chain_valid[CELLS] || can_load;
   assign req_chan.ready = advance;

   fpwm_front #(.FRACT_BITS(FRACT_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .up_valid       (req_chan.valid),
      .up_vco_hz      (req_chan.vco_hz),
      .up_is_transmit (req_chan.is_transmit),
      .dn_valid       (chain_valid[0]),
      .dn_num         (chain_num[0]),
      .dn_div         (chain_div[0]),
      .dn_tx          (chain_tx[0])
   );

   assign chain_rem[0] = '0;
   assign chain_quo[0] = '0;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      fpwm_cell #(.NUM_W(NUM_W), .QUO_W(QUO_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ref_freq (ref_ff),
         .up_valid (chain_valid[k]),
         .up_rem   (chain_rem[k]),
         .up_num   (chain_num[k]),
         .up_quo   (chain_quo[k]),
         .up_div   (chain_div[k]),
         .up_tx    (chain_tx[k]),
         .dn_valid (chain_valid[k+1]),
         .dn_rem   (chain_rem[k+1]),
         .dn_num   (chain_num[k+1]),
         .dn_quo   (chain_quo[k+1]),
         .dn_div   (chain_div[k+1]),
         .dn_tx    (chain_tx[k+1])
      );
   end

   fpwm_serializer #(.FRACT_BITS(FRACT_BITS)) u_serializer (
      .clock        (clock),
      .reset        (reset),
      .tail_valid   (chain_valid[CELLS]),
      .tail_quo     (chain_quo[CELLS]),
      .tail_div     (chain_div[CELLS]),
      .tail_tx      (chain_tx[CELLS]),
      .can_load     (can_load),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_out_byte (rsp_chan.out_byte),
      .rsp_last     (rsp_chan.last)
   );

   // a stalled tail must block new requests
   `FPWM_ASSERT_NOW(a_stall_blocks_req, clock, reset, chain_valid[CELLS] && !can_load, !req_chan.ready)
   // a held request in the input stage stays put
   `FPWM_ASSERT_NEXT(a_front_holds, clock, reset, chain_valid[0] && !advance, chain_valid[0])
   // after the final byte with nothing to load, the output goes quiet
   `FPWM_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_chan.valid && rsp_chan.last && rsp_chan.ready && !chain_valid[CELLS], !rsp_chan.valid)

endmodule
